// ----- design/ppl_pkg.sv -----
// Shared constants and types for the partition point location histogram unit.
package ppl_pkg;

	localparam int MAX_PARTS  = 1023;
	localparam int COORD_BITS = 16;
	localparam int COUNT_BITS = 11;
	localparam int OUT_BITS   = 11;
	localparam int MAX_LINES  = 44;

	localparam int IDX_BITS  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int BIN_BITS  = $clog2(MAX_PARTS + 1);
	localparam int MULT_BITS = $clog2(MAX_PARTS + 2);
	localparam int LINE_BITS = $clog2(MAX_LINES + 1);
	localparam int PROD_BITS = 2 * (COORD_BITS + 1);

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_LOCATE = 2'd1,
		CMD_REPORT = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_LEFT_X   = 2'd0,
		REG_TOP_Y    = 2'd1,
		REG_BOTTOM_Y = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	// result of one scan pass over the bin counts
	typedef struct packed {
		logic                  any;
		logic [COUNT_BITS-1:0] best;
		logic [MULT_BITS-1:0]  mult;
	} scan_res_t;

endpackage

// ----- design/ppl_cross.sv -----
// Shared cross-product side test: registered products, strict compare.
module ppl_cross import ppl_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	input  logic [COORD_BITS-1:0] tx,
	input  logic [COORD_BITS-1:0] bx,
	input  logic [COORD_BITS-1:0] ty,
	input  logic [COORD_BITS-1:0] by,
	output logic                  gt
);

	logic signed [COORD_BITS:0]  dpx, ddy, dpy, ddx;
	logic signed [PROD_BITS-1:0] lhs_s1, rhs_s1;

	// operand differences, one bit wider and signed
	assign dpx = $signed({1'b0, px}) - $signed({1'b0, bx});
	assign ddy = $signed({1'b0, ty}) - $signed({1'b0, by});
	assign dpy = $signed({1'b0, py}) - $signed({1'b0, by});
	assign ddx = $signed({1'b0, tx}) - $signed({1'b0, bx});

	always_ff @(posedge clk) begin
		if (en) begin
			lhs_s1 <= PROD_BITS'(dpx * ddy);
			rhs_s1 <= PROD_BITS'(dpy * ddx);
		end
	end

	assign gt = lhs_s1 > rhs_s1;

endmodule

// ----- design/ppl_scan.sv -----
// Scan accumulator: smallest count above a floor and how many bins hold it.
module ppl_scan import ppl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clr,
	input  logic                  vld,
	input  logic [COUNT_BITS-1:0] cnt,
	input  logic [COUNT_BITS-1:0] floor_cnt,
	output scan_res_t             res
);

	scan_res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (clr) begin
			res_q <= '0;
		end else if (vld && cnt > floor_cnt) begin
			priority if (!res_q.any || cnt < res_q.best) begin
				res_q.any  <= 1'b1;
				res_q.best <= cnt;
				res_q.mult <= MULT_BITS'(1);
			end else if (cnt == res_q.best) begin
				res_q.mult <= res_q.mult + MULT_BITS'(1);
			end
		end
	end

	assign res = res_q;

endmodule

// ----- design/partition_point_location_histogram_unit.sv -----
// Partition point location histogram unit: top level, sequencer and tables.
// One word at a time, n partitions held. After reset a clearing pass zeroes
// the bin counts before the first word is taken. A load walks from the end of
// the table through the table memory, read then write, shifting entries up
// until it reaches the insert place. A locate makes up to floor(log2(n+1))+1
// search steps, each a table read, a product in the shared cross-product unit
// and a compare, then reads and writes the count of the bin found. A report
// scans the counts once per line, waits for each line to be taken, then
// clears n+1 counts.
module partition_point_location_histogram_unit import ppl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            command,
	input  logic [COORD_BITS-1:0] upper_x,
	input  logic [COORD_BITS-1:0] lower_x,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_BITS-1:0]   items_per_bin,
	output logic [OUT_BITS-1:0]   bins_with_count,
	output logic                  last_line
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LD_RD, S_LD_WR, S_LC_RD, S_LC_MUL, S_LC_CMP,
		S_LC_CRD, S_LC_CWR, S_RP_SCAN, S_RP_DONE, S_RP_EVAL, S_RP_OUT, S_RP_CLR
	} state_t;

	state_t                     state_q;
	logic [COORD_BITS-1:0]      left_x_q, top_y_q, bottom_y_q;
	logic [COORD_BITS-1:0]      ax_q, ay_q;
	logic [BIN_BITS-1:0]        part_cnt_q, i_q, bin_q, mid_q;
	logic signed [BIN_BITS+1:0] lo_q, hi_q;
	logic [BIN_BITS+1:0]        mid_sum;
	logic [BIN_BITS-1:0]        mid;
	logic                       rd_vld_s1;
	logic [COUNT_BITS-1:0]      prev_q, pend_cnt_q;
	logic [MULT_BITS-1:0]       pend_mult_q;
	logic                       pend_q;
	logic [LINE_BITS-1:0]       lines_q;

	// table and count memories
	logic [COORD_BITS-1:0] top_mem [MAX_PARTS];
	logic [COORD_BITS-1:0] bot_mem [MAX_PARTS];
	logic [COUNT_BITS-1:0] cnt_mem [MAX_PARTS+1];
	logic                  tbl_we, cnt_we;
	logic [IDX_BITS-1:0]   tbl_waddr, tbl_raddr;
	logic [COORD_BITS-1:0] tbl_wtop, tbl_wbot, top_rd_q, bot_rd_q;
	logic [BIN_BITS-1:0]   cnt_waddr, cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd_q;

	logic                  x_en, x_gt;
	logic [COORD_BITS-1:0] x_tx, x_bx;
	logic                  sc_clr;
	scan_res_t             sc_res;

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			top_mem[tbl_waddr] <= tbl_wtop;
			bot_mem[tbl_waddr] <= tbl_wbot;
		end
		top_rd_q <= top_mem[tbl_raddr];
		bot_rd_q <= bot_mem[tbl_raddr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	// binary search midpoint; lo and hi are non-negative whenever it is used
	assign mid_sum = {1'b0, lo_q[BIN_BITS:0]} + {1'b0, hi_q[BIN_BITS:0]};
	assign mid     = mid_sum[BIN_BITS:1];

	// memory port and unit control
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = IDX_BITS'(i_q);
		tbl_wtop  = ax_q;
		tbl_wbot  = ay_q;
		tbl_raddr = IDX_BITS'(i_q - BIN_BITS'(1));
		cnt_we    = 1'b0;
		cnt_waddr = i_q;
		cnt_wdata = '0;
		cnt_raddr = i_q;
		x_en      = 1'b0;
		x_tx      = left_x_q;
		x_bx      = left_x_q;
		sc_clr    = 1'b0;
		unique case (state_q)
			S_CLR, S_RP_CLR: cnt_we = 1'b1;
			S_LD_WR: begin
				tbl_we = 1'b1;
				if (top_rd_q > ax_q) begin
					tbl_wtop = top_rd_q;
					tbl_wbot = bot_rd_q;
				end
			end
			S_LD_RD: tbl_we = (i_q == '0);
			S_LC_RD: tbl_raddr = IDX_BITS'(mid - BIN_BITS'(1));
			S_LC_MUL: begin
				x_en = 1'b1;
				if (mid_q != '0) begin
					x_tx = top_rd_q;
					x_bx = bot_rd_q;
				end
			end
			S_LC_CRD: cnt_raddr = bin_q;
			S_LC_CWR: begin
				cnt_waddr = bin_q;
				cnt_wdata = cnt_rd_q + COUNT_BITS'(1);
				cnt_we    = (cnt_rd_q != '1);
			end
			S_IDLE, S_RP_EVAL: sc_clr = 1'b1;
			default: ;
		endcase
	end

	ppl_cross u_cross (
		.clk (clk),
		.en  (x_en),
		.px  (ax_q),
		.py  (ay_q),
		.tx  (x_tx),
		.bx  (x_bx),
		.ty  (top_y_q),
		.by  (bottom_y_q),
		.gt  (x_gt)
	);

	ppl_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (sc_clr),
		.vld       (rd_vld_s1),
		.cnt       (cnt_rd_q),
		.floor_cnt (prev_q),
		.res       (sc_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_x_q   <= '0;
			top_y_q    <= '0;
			bottom_y_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LEFT_X:   left_x_q   <= cfg_data;
				REG_TOP_Y:    top_y_q    <= cfg_data;
				REG_BOTTOM_Y: bottom_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLR;
			part_cnt_q      <= '0;
			i_q             <= '0;
			bin_q           <= '0;
			mid_q           <= '0;
			lo_q            <= '0;
			hi_q            <= '0;
			rd_vld_s1       <= 1'b0;
			prev_q          <= '0;
			pend_q          <= 1'b0;
			pend_cnt_q      <= '0;
			pend_mult_q     <= '0;
			lines_q         <= '0;
			out_valid       <= 1'b0;
			last_line       <= 1'b0;
			items_per_bin   <= '0;
			bins_with_count <= '0;
			ax_q            <= '0;
			ay_q            <= '0;
		end else begin
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					i_q <= i_q + BIN_BITS'(1);
					if (i_q == BIN_BITS'(MAX_PARTS)) begin
						i_q     <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						unique case (cmd_t'(command))
							CMD_LOAD: begin
								ax_q <= upper_x;
								ay_q <= lower_x;
								i_q  <= part_cnt_q;
								if (part_cnt_q < BIN_BITS'(MAX_PARTS))
									state_q <= S_LD_RD;
							end
							CMD_LOCATE: begin
								ax_q    <= point_x;
								ay_q    <= point_y;
								lo_q    <= '0;
								hi_q    <= $signed({2'b0, part_cnt_q});
								bin_q   <= '0;
								state_q <= S_LC_RD;
							end
							CMD_REPORT: begin
								i_q     <= '0;
								prev_q  <= '0;
								pend_q  <= 1'b0;
								lines_q <= '0;
								state_q <= S_RP_SCAN;
							end
							default: ;
						endcase
					end
				end
				// insertion walk from the end of the table
				S_LD_RD: begin
					if (i_q == '0) begin
						part_cnt_q <= part_cnt_q + BIN_BITS'(1);
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_LD_WR;
					end
				end
				S_LD_WR: begin
					if (top_rd_q > ax_q) begin
						i_q     <= i_q - BIN_BITS'(1);
						state_q <= S_LD_RD;
					end else begin
						part_cnt_q <= part_cnt_q + BIN_BITS'(1);
						state_q    <= S_IDLE;
					end
				end
				// binary search over wall and partitions
				S_LC_RD: begin
					if (lo_q > hi_q) begin
						state_q <= S_LC_CRD;
					end else begin
						mid_q   <= mid;
						state_q <= S_LC_MUL;
					end
				end
				S_LC_MUL: state_q <= S_LC_CMP;
				S_LC_CMP: begin
					if (x_gt) begin
						bin_q <= mid_q;
						lo_q  <= $signed({2'b0, mid_q}) + $signed((BIN_BITS+2)'(1));
					end else begin
						hi_q  <= $signed({2'b0, mid_q}) - $signed((BIN_BITS+2)'(1));
					end
					state_q <= S_LC_RD;
				end
				S_LC_CRD: state_q <= S_LC_CWR;
				S_LC_CWR: state_q <= S_IDLE;
				// one pass over the counts per report line
				S_RP_SCAN: begin
					rd_vld_s1 <= 1'b1;
					i_q       <= i_q + BIN_BITS'(1);
					if (i_q == part_cnt_q)
						state_q <= S_RP_DONE;
				end
				S_RP_DONE: state_q <= S_RP_EVAL;
				S_RP_EVAL: begin
					i_q    <= '0;
					prev_q <= sc_res.best;
					if (pend_q) begin
						items_per_bin   <= OUT_BITS'(pend_cnt_q);
						bins_with_count <= OUT_BITS'(pend_mult_q);
						last_line       <= !sc_res.any ||
							(lines_q == LINE_BITS'(MAX_LINES - 1));
						out_valid       <= 1'b1;
						lines_q         <= lines_q + LINE_BITS'(1);
						pend_q          <= sc_res.any &&
							(lines_q != LINE_BITS'(MAX_LINES - 1));
						state_q         <= S_RP_OUT;
					end else begin
						pend_q  <= sc_res.any;
						state_q <= sc_res.any ? S_RP_SCAN : S_RP_CLR;
					end
					pend_cnt_q  <= sc_res.best;
					pend_mult_q <= sc_res.mult;
				end
				S_RP_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= pend_q ? S_RP_SCAN : S_RP_CLR;
					end
				end
				S_RP_CLR: begin
					i_q <= i_q + BIN_BITS'(1);
					if (i_q == part_cnt_q) begin
						i_q        <= '0;
						part_cnt_q <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

`ifndef ASSERT_OFF
	a_out_only_in_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_RP_OUT)
		else $error("result word outside report output state");
	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a result word waits");
	a_table_bound: assert property (@(posedge clk) disable iff (!arst_n)
		part_cnt_q <= BIN_BITS'(MAX_PARTS))
		else $error("partition count beyond table depth");
	a_nonzero_line: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> items_per_bin != '0 && bins_with_count != '0)
		else $error("report line with zero count");
`endif

endmodule
